/* sv/trm_pkg.sv */
// trm_pkg: shared types and constants for the toy register machine execute block.
// Holds the request/response payload structs, the opcode enum and the write-port struct.
// No dependencies.
package trm_pkg;

    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;
    localparam int OP_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_MOV = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_JEQ = 3'd3,
        OP_JGT = 3'd4,
        OP_JLT = 3'd5
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic [REG_IDX_W-1:0]   dest_index;
        logic                   a_is_reg;
        logic [REG_IDX_W-1:0]   a_index;
        logic signed [DATA_W-1:0] a_imm;
        logic                   b_is_reg;
        logic [REG_IDX_W-1:0]   b_index;
        logic signed [DATA_W-1:0] b_imm;
        logic                   c_is_reg;
        logic [REG_IDX_W-1:0]   c_index;
        logic signed [DATA_W-1:0] c_imm;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] next_index;
        logic                     wrote;
        logic signed [DATA_W-1:0] written_value;
    } t_rsp;

    // Register file write port
    typedef struct packed {
        logic                   en;
        logic [REG_IDX_W-1:0]   idx;
        logic [DATA_W-1:0]      value;
    } t_wr;

endpackage

/* sv/trm_regfile.sv */
// trm_regfile: register file of the machine, command index in the last entry.
// Three combinational read ports (the command index reads stepped), one update per request.
// Depends on trm_pkg.
module trm_regfile #(
    parameter int NUM_REGS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_upd,
    input  trm_pkg::t_wr                        i_wr,
    input  logic [trm_pkg::DATA_W-1:0]          i_next_pc,
    input  logic [trm_pkg::REG_IDX_W-1:0]       i_a_idx,
    input  logic [trm_pkg::REG_IDX_W-1:0]       i_b_idx,
    input  logic [trm_pkg::REG_IDX_W-1:0]       i_c_idx,
    output logic [trm_pkg::DATA_W-1:0]          o_a_val,
    output logic [trm_pkg::DATA_W-1:0]          o_b_val,
    output logic [trm_pkg::DATA_W-1:0]          o_c_val,
    output logic [trm_pkg::DATA_W-1:0]          o_pc_val
);

    localparam int PC = NUM_REGS - 1;

    logic [trm_pkg::DATA_W-1:0] r_regs [NUM_REGS];
    logic [trm_pkg::DATA_W-1:0] pc_step;

    assign o_pc_val = r_regs[PC];
    assign pc_step  = r_regs[PC] + trm_pkg::DATA_W'(1);

    // Indexes at or beyond the register count read zero
    always_comb begin
        o_a_val = '0;
        o_b_val = '0;
        o_c_val = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            if (32'(i_a_idx) == 32'(i)) begin
                o_a_val = (i == PC) ? pc_step : r_regs[i];
            end
            if (32'(i_b_idx) == 32'(i)) begin
                o_b_val = (i == PC) ? pc_step : r_regs[i];
            end
            if (32'(i_c_idx) == 32'(i)) begin
                o_c_val = (i == PC) ? pc_step : r_regs[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else if (i_upd) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                if (i == PC) begin
                    r_regs[i] <= i_next_pc;
                end else if (i_wr.en && (32'(i_wr.idx) == 32'(i))) begin
                    r_regs[i] <= i_wr.value;
                end
            end
        end
    end

endmodule

/* sv/trm_exec.sv */
// trm_exec: combinational execute of one pre-decoded instruction.
// Selects operands, does the add/sub or compare, forms the next command index.
// Depends on trm_pkg.
module trm_exec #(
    parameter int NUM_REGS = 8
) (
    input  trm_pkg::t_req                   i_req,
    input  logic [trm_pkg::DATA_W-1:0]      i_a_reg,
    input  logic [trm_pkg::DATA_W-1:0]      i_b_reg,
    input  logic [trm_pkg::DATA_W-1:0]      i_c_reg,
    input  logic [trm_pkg::DATA_W-1:0]      i_pc,
    output trm_pkg::t_wr                    o_wr,
    output logic [trm_pkg::DATA_W-1:0]      o_next_pc,
    output trm_pkg::t_rsp                   o_rsp
);

    logic [trm_pkg::DATA_W-1:0] a;
    logic [trm_pkg::DATA_W-1:0] b;
    logic [trm_pkg::DATA_W-1:0] c;
    logic [trm_pkg::DATA_W-1:0] val;
    logic                       is_write;
    logic                       jump;
    logic                       wr_ok;
    logic                       wr_pc;

    assign a = i_req.a_is_reg ? i_a_reg : i_req.a_imm;
    assign b = i_req.b_is_reg ? i_b_reg : i_req.b_imm;
    assign c = i_req.c_is_reg ? i_c_reg : i_req.c_imm;

    always_comb begin
        val      = '0;
        is_write = 1'b0;
        jump     = 1'b0;
        unique case (trm_pkg::t_op'(i_req.operation))
            trm_pkg::OP_MOV: begin
                val      = a;
                is_write = 1'b1;
            end
            trm_pkg::OP_ADD: begin
                val      = a + b;
                is_write = 1'b1;
            end
            trm_pkg::OP_SUB: begin
                val      = a - b;
                is_write = 1'b1;
            end
            trm_pkg::OP_JEQ: jump = (a == b);
            trm_pkg::OP_JGT: jump = ($signed(a) > $signed(b));
            trm_pkg::OP_JLT: jump = ($signed(a) < $signed(b));
            default: ;
        endcase
    end

    assign wr_ok = is_write && (32'(i_req.dest_index) < 32'(NUM_REGS));
    assign wr_pc = wr_ok && (32'(i_req.dest_index) == 32'(NUM_REGS - 1));

    // Stepped index plus (c - 1) collapses to old index plus c
    always_comb begin
        if (wr_pc) begin
            o_next_pc = val;
        end else if (jump) begin
            o_next_pc = i_pc + c;
        end else begin
            o_next_pc = i_pc + trm_pkg::DATA_W'(1);
        end
    end

    assign o_wr.en    = wr_ok;
    assign o_wr.idx   = i_req.dest_index;
    assign o_wr.value = val;

    assign o_rsp.next_index    = o_next_pc;
    assign o_rsp.wrote         = wr_ok;
    assign o_rsp.written_value = wr_ok ? val : '0;

endmodule

/* sv/toy_register_machine_execute.sv */
// toy_register_machine_execute: top level of the register machine execute block.
// Input register, register file plus execute logic, result register.
// Depends on trm_pkg, trm_regfile, trm_exec.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+---------------------------
//  request   | in        | i_req_valid / o_req_ready  | i_req (trm_pkg::t_req)
//  response  | out       | o_rsp_valid / i_rsp_ready  | o_rsp (trm_pkg::t_rsp)
//
// An accepted request is held in the input register, then moves into the result
// register once that is free or being drained, and the response turns valid there.
// One request is accepted per cycle while the input register is free or advancing;
// the register file read, add/compare and write-back of one request all happen
// between the two registers, so each request sees the previous one's writes.
// Reset clears all registers of the machine, the command index included, and both
// valid flags. A stalled response holds; the input register still accepts a new
// request while its own request is moving into the result register.
module toy_register_machine_execute #(
    parameter int NUM_REGS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  trm_pkg::t_req   i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output trm_pkg::t_rsp   o_rsp
);

    // Input register
    logic           r_req_valid;
    logic           n_req_valid;
    trm_pkg::t_req  r_req;

    // Result register
    logic           r_rsp_valid;
    logic           n_rsp_valid;
    trm_pkg::t_rsp  r_rsp;

    logic                       req_acc;
    logic                       advance;
    logic [trm_pkg::DATA_W-1:0] a_reg;
    logic [trm_pkg::DATA_W-1:0] b_reg;
    logic [trm_pkg::DATA_W-1:0] c_reg;
    logic [trm_pkg::DATA_W-1:0] pc_val;
    logic [trm_pkg::DATA_W-1:0] next_pc;
    trm_pkg::t_wr               wr;
    trm_pkg::t_rsp              rsp;

    // Advance the held request when the result register is free or being drained;
    // the register file commits on that same edge.
    assign advance     = r_req_valid && (!r_rsp_valid || i_rsp_ready);
    assign o_req_ready = !r_req_valid || advance;
    assign req_acc     = i_req_valid && o_req_ready;

    trm_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (advance),
        .i_wr      (wr),
        .i_next_pc (next_pc),
        .i_a_idx   (r_req.a_index),
        .i_b_idx   (r_req.b_index),
        .i_c_idx   (r_req.c_index),
        .o_a_val   (a_reg),
        .o_b_val   (b_reg),
        .o_c_val   (c_reg),
        .o_pc_val  (pc_val)
    );

    trm_exec #(
        .NUM_REGS (NUM_REGS)
    ) u_exec (
        .i_req     (r_req),
        .i_a_reg   (a_reg),
        .i_b_reg   (b_reg),
        .i_c_reg   (c_reg),
        .i_pc      (pc_val),
        .o_wr      (wr),
        .o_next_pc (next_pc),
        .o_rsp     (rsp)
    );

    always_comb begin
        n_req_valid = r_req_valid;
        if (req_acc) begin
            n_req_valid = 1'b1;
        end else if (advance) begin
            n_req_valid = 1'b0;
        end

        n_rsp_valid = r_rsp_valid;
        if (advance) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_req_valid <= n_req_valid;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Payload: request captured on accept, result on advance, both hold otherwise
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req <= i_req;
        end
        if (advance) begin
            r_rsp <= rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for toy_register_machine_execute.
// Keeps a shadow register file, predicts every response, checks them in order.
// Depends on trm_pkg and the toy_register_machine_execute RTL.
module testbench;

    localparam int MACHINE_REGS   = 8;
    localparam int PC_INDEX       = MACHINE_REGS - 1;
    localparam int RANDOM_COUNT   = 1650;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_OFF_AFTER = 400;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_CYCLES   = 8;

    // Operation codes the machine leaves unused
    localparam logic [trm_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [trm_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef logic [trm_pkg::DATA_W-1:0] t_word;

    // Shadow of the machine: register file plus the responses it still owes.
    class t_machine_shadow;
        t_word          regs [MACHINE_REGS];
        trm_pkg::t_rsp  owed_rsp [$];
        int             errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            errors = 0;
        endfunction

        function t_word operand(logic is_reg, logic [trm_pkg::REG_IDX_W-1:0] idx,
                                t_word imm);
            if (!is_reg) return imm;
            return (idx < MACHINE_REGS) ? regs[idx] : '0;
        endfunction

        // Execute one accepted request against the shadow and queue its response.
        function void note_request(trm_pkg::t_req r);
            t_word          a, b, c, val;
            logic           do_write, taken;
            trm_pkg::t_rsp  rsp;
            do_write = 1'b0;
            taken    = 1'b0;
            val      = '0;
            // Step the command index first so sources naming it see the new value.
            regs[PC_INDEX] = regs[PC_INDEX] + 1;
            a = operand(r.a_is_reg, r.a_index, r.a_imm);
            b = operand(r.b_is_reg, r.b_index, r.b_imm);
            c = operand(r.c_is_reg, r.c_index, r.c_imm);
            case (r.operation)
                trm_pkg::OP_MOV: begin val = a;     do_write = 1'b1; end
                trm_pkg::OP_ADD: begin val = a + b; do_write = 1'b1; end
                trm_pkg::OP_SUB: begin val = a - b; do_write = 1'b1; end
                trm_pkg::OP_JEQ: taken = (a == b);
                trm_pkg::OP_JGT: taken = ($signed(a) > $signed(b));
                trm_pkg::OP_JLT: taken = ($signed(a) < $signed(b));
                default: ;
            endcase
            if (taken) regs[PC_INDEX] = regs[PC_INDEX] + (c - 1);
            if (do_write && r.dest_index < MACHINE_REGS) begin
                regs[r.dest_index] = val;
                rsp.wrote = 1'b1;
            end else begin
                val = '0;
                rsp.wrote = 1'b0;
            end
            rsp.written_value = val;
            rsp.next_index    = regs[PC_INDEX];
            owed_rsp = {owed_rsp, rsp};
        endfunction

        function void check_response(trm_pkg::t_rsp got);
            trm_pkg::t_rsp want;
            if (owed_rsp.size() == 0) begin
                $display("%0t: response with none owed, actual %h", $time, got);
                errors++;
                return;
            end
            want = owed_rsp.pop_front();
            if (got.next_index !== want.next_index) begin
                $display("%0t: next_index expected %h actual %h",
                         $time, want.next_index, got.next_index);
                errors++;
            end
            if (got.wrote !== want.wrote) begin
                $display("%0t: wrote expected %b actual %b", $time, want.wrote, got.wrote);
                errors++;
            end
            if (got.written_value !== want.written_value) begin
                $display("%0t: written_value expected %h actual %h",
                         $time, want.written_value, got.written_value);
                errors++;
            end
        endfunction

        function int pending();
            return owed_rsp.size();
        endfunction
    endclass

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_req_valid = 1'b0;
    logic           o_req_ready;
    trm_pkg::t_req  i_req       = '0;
    logic           o_rsp_valid;
    logic           i_rsp_ready = 1'b0;
    trm_pkg::t_rsp  o_rsp;

    t_machine_shadow shadow = new();
    int              rsp_seen  = 0;
    int              req_sent  = 0;

    toy_register_machine_execute #(.NUM_REGS(MACHINE_REGS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    // Build one request from its fields.
    function automatic trm_pkg::t_req instr(
        logic [trm_pkg::OP_W-1:0] op, logic [trm_pkg::REG_IDX_W-1:0] dest,
        logic ar, logic [trm_pkg::REG_IDX_W-1:0] ai, t_word aimm,
        logic br, logic [trm_pkg::REG_IDX_W-1:0] bi, t_word bimm,
        logic cr, logic [trm_pkg::REG_IDX_W-1:0] ci, t_word cimm);
        trm_pkg::t_req r;
        r.operation  = op;
        r.dest_index = dest;
        r.a_is_reg   = ar;
        r.a_index    = ai;
        r.a_imm      = aimm;
        r.b_is_reg   = br;
        r.b_index    = bi;
        r.b_imm      = bimm;
        r.c_is_reg   = cr;
        r.c_index    = ci;
        r.c_imm      = cimm;
        return r;
    endfunction

    // Pick an immediate, leaning on the extremes and small values near zero.
    function automatic t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4:       return t_word'($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Random instruction: mostly legal operations, a few unused codes.
    function automatic trm_pkg::t_req random_instr();
        trm_pkg::t_req r;
        int            sel;
        sel          = $urandom_range(0, 19);
        if (sel < 18)
            r.operation = trm_pkg::OP_W'(sel % 6);
        else
            r.operation = (sel == 18) ? OP_SPARE_LO : OP_SPARE_HI;
        r.dest_index = trm_pkg::REG_IDX_W'($urandom_range(0, 7));
        r.a_is_reg   = 1'($urandom_range(0, 1));
        r.a_index    = trm_pkg::REG_IDX_W'($urandom_range(0, 7));
        r.a_imm      = pick_word();
        r.b_is_reg   = 1'($urandom_range(0, 1));
        r.b_index    = trm_pkg::REG_IDX_W'($urandom_range(0, 7));
        r.b_imm      = pick_word();
        r.c_is_reg   = 1'($urandom_range(0, 1));
        r.c_index    = trm_pkg::REG_IDX_W'($urandom_range(0, 7));
        r.c_imm      = pick_word();
        // Mirror the first source often so equality jumps get taken.
        if (r.operation inside {trm_pkg::OP_JEQ, trm_pkg::OP_JGT, trm_pkg::OP_JLT}
            && $urandom_range(0, 2) == 0) begin
            r.b_is_reg = r.a_is_reg;
            r.b_index  = r.a_index;
            r.b_imm    = r.a_imm;
        end
        return r;
    endfunction

    // Idle length: mostly none or short, sometimes long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request; call at a rising edge. Returns on accept or after the gap.
    task automatic send_request(trm_pkg::t_req r);
        int gap;
        i_req       <= r;
        i_req_valid <= 1'b1;
        // Sample ready at the falling edge, where nothing moves until the next rise.
        @(negedge i_clk);
        while (!o_req_ready) @(negedge i_clk);
        shadow.note_request(r);
        @(posedge i_clk);
        req_sent++;
        // Run back-to-back for a stretch every few hundred requests.
        gap = (req_sent % 300 < 60) ? 0 : pick_gap();
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Response side: random ready pattern, plus one long hold-off to back up the pipe.
    initial begin
        bit held_off;
        int r;
        held_off = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held_off && rsp_seen >= HOLD_OFF_AFTER) begin
                i_rsp_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge i_clk);
                held_off = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_rsp_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end else if (r < 95) begin
                    i_rsp_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_rsp_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                end
            end
        end
    end

    // Check each response at the falling edge before the rising edge that takes it.
    always @(negedge i_clk) begin
        if (i_rst_n && o_rsp_valid === 1'b1 && i_rsp_ready) begin
            shadow.check_response(o_rsp);
            rsp_seen++;
        end
    end

    // Abort when neither channel moves for too long.
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(negedge i_clk);
            if (!i_rst_n || (i_req_valid && o_req_ready === 1'b1)
                         || (o_rsp_valid === 1'b1 && i_rsp_ready))
                idle = 0;
            else
                idle++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, wraparound, every operation, command index corner cases.
        send_request(instr(trm_pkg::OP_MOV, 3'd0, 1'b0, 3'd0, 32'h7fff_ffff,
                           1'b0, 3'd0, 32'h0, 1'b0, 3'd0, 32'h0));
        send_request(instr(trm_pkg::OP_MOV, 3'd1, 1'b0, 3'd0, 32'h8000_0000,
                           1'b0, 3'd0, 32'h0, 1'b0, 3'd0, 32'h0));
        // Wrap on add and sub.
        send_request(instr(trm_pkg::OP_ADD, 3'd2, 1'b1, 3'd0, 32'h0,
                           1'b0, 3'd0, 32'h1, 1'b0, 3'd0, 32'h0));
        send_request(instr(trm_pkg::OP_SUB, 3'd3, 1'b1, 3'd1, 32'h0,
                           1'b0, 3'd0, 32'h1, 1'b0, 3'd0, 32'h0));
        send_request(instr(trm_pkg::OP_ADD, 3'd4, 1'b1, 3'd0, 32'h0,
                           1'b1, 3'd1, 32'h0, 1'b0, 3'd0, 32'h0));
        send_request(instr(trm_pkg::OP_SUB, 3'd5, 1'b1, 3'd1, 32'h0,
                           1'b1, 3'd0, 32'h0, 1'b0, 3'd0, 32'h0));
        // Read the command index: must see the stepped value.
        send_request(instr(trm_pkg::OP_MOV, 3'd6, 1'b1, 3'd7, 32'h0,
                           1'b0, 3'd0, 32'h0, 1'b0, 3'd0, 32'h0));
        // Write the command index: replaces the stepped value.
        send_request(instr(trm_pkg::OP_MOV, 3'd7, 1'b0, 3'd0, 32'h0000_0100,
                           1'b0, 3'd0, 32'h0, 1'b0, 3'd0, 32'h0));
        send_request(instr(trm_pkg::OP_ADD, 3'd7, 1'b1, 3'd7, 32'h0,
                           1'b0, 3'd0, 32'hffff_ffff, 1'b0, 3'd0, 32'h0));
        // Equal jump taken and not taken.
        send_request(instr(trm_pkg::OP_JEQ, 3'd0, 1'b0, 3'd0, 32'h5,
                           1'b0, 3'd0, 32'h5, 1'b0, 3'd0, 32'h10));
        send_request(instr(trm_pkg::OP_JEQ, 3'd0, 1'b0, 3'd0, 32'h5,
                           1'b0, 3'd0, 32'h6, 1'b0, 3'd0, 32'h10));
        // Greater: signed compare, negative against positive both ways.
        send_request(instr(trm_pkg::OP_JGT, 3'd0, 1'b1, 3'd0, 32'h0,
                           1'b1, 3'd1, 32'h0, 1'b0, 3'd0, 32'hffff_fff0));
        send_request(instr(trm_pkg::OP_JGT, 3'd0, 1'b0, 3'd0, 32'hffff_ffff,
                           1'b0, 3'd0, 32'h1, 1'b0, 3'd0, 32'h20));
        send_request(instr(trm_pkg::OP_JGT, 3'd0, 1'b0, 3'd0, 32'h3,
                           1'b0, 3'd0, 32'h3, 1'b0, 3'd0, 32'h20));
        // Less: taken with the offset from a register, then not taken.
        send_request(instr(trm_pkg::OP_JLT, 3'd0, 1'b1, 3'd1, 32'h0,
                           1'b1, 3'd0, 32'h0, 1'b1, 3'd2, 32'h0));
        send_request(instr(trm_pkg::OP_JLT, 3'd0, 1'b0, 3'd0, 32'h1,
                           1'b0, 3'd0, 32'hffff_ffff, 1'b0, 3'd0, 32'h20));
        // Zero offset steps the index back by one; extreme offsets wrap.
        send_request(instr(trm_pkg::OP_JEQ, 3'd0, 1'b0, 3'd0, 32'h0,
                           1'b0, 3'd0, 32'h0, 1'b0, 3'd0, 32'h0));
        send_request(instr(trm_pkg::OP_JEQ, 3'd0, 1'b1, 3'd7, 32'h0,
                           1'b1, 3'd7, 32'h0, 1'b0, 3'd0, 32'h8000_0000));
        send_request(instr(trm_pkg::OP_JLT, 3'd0, 1'b0, 3'd0, 32'h8000_0000,
                           1'b0, 3'd0, 32'h7fff_ffff, 1'b0, 3'd0, 32'h7fff_ffff));
        // Unused operation codes: only the index steps.
        send_request(instr(OP_SPARE_LO, 3'd0, 1'b0, 3'd0, 32'hffff_ffff,
                           1'b0, 3'd0, 32'hffff_ffff, 1'b0, 3'd0, 32'hffff_ffff));
        send_request(instr(OP_SPARE_HI, 3'd5, 1'b1, 3'd7, 32'h0,
                           1'b1, 3'd7, 32'h0, 1'b1, 3'd7, 32'h0));
        // Compare against the command index itself.
        send_request(instr(trm_pkg::OP_JGT, 3'd0, 1'b1, 3'd7, 32'h0,
                           1'b0, 3'd0, 32'h0, 1'b1, 3'd3, 32'h0));

        repeat (RANDOM_COUNT) send_request(random_instr());

        // Drop valid, drain the owed responses, then let the pipe settle.
        i_req_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
